@@ rtl/bvg_pkg.sv @@
package bvg_pkg;

  localparam int BVG_SAMPLE_COUNT = 12;

  localparam int SAMPLE_W   = 12;
  localparam int SUM_W      = 18;
  localparam int MV_W       = 13;
  localparam int SLOPE_W    = 12;
  localparam int OFFSET_W   = 19;
  localparam int CFG_DATA_W = 19;
  localparam int CFG_IDX_W  = 3;
  localparam int PROD_W     = 2 * SAMPLE_W;
  localparam int CONV_W     = PROD_W + 2;
  localparam int DIV_W      = 25;
  localparam int DIVR_W     = 14;

  localparam logic [SAMPLE_W-1:0] SAMPLE_ALL_ONES = '1;
  localparam logic [SLOPE_W-1:0]  DEFAULT_GAIN    = 12'd1200;
  localparam logic [DIVR_W-1:0]   CAL_SCALE       = 14'd10000;
  localparam logic [MV_W-1:0]     MV_LIMIT        = 13'd8191;

  localparam logic [MV_W-1:0] VOLT_MIN_RESET  = 13'd3600;
  localparam logic [MV_W-1:0] VOLT_MAX_RESET  = 13'd4200;
  localparam logic [MV_W-1:0] VOLT_STEP_RESET = 13'd120;

  localparam logic [CFG_IDX_W-1:0] REG_CAL_SLOPE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_MAX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_STEP  = 3'd4;

endpackage

@@ rtl/bvg_div.sv @@
module bvg_div
  import bvg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [DIVR_W-1:0] divisor,
  output logic              done,
  output logic [DIV_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIVR_W-1:0] rem;
  logic [DIVR_W-1:0] dvsr;
  logic [DIVR_W:0]   trial;
  logic              fits;

  // one quotient bit per cycle, restoring
  assign trial = {rem, quotient[DIV_W-1]};
  assign fits  = (trial >= {1'b0, dvsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvsr     <= divisor;
    end else if (busy) begin
      quotient <= {quotient[DIV_W-2:0], fits};
      rem      <= fits ? DIVR_W'(trial - {1'b0, dvsr}) : trial[DIVR_W-1:0];
    end
  end

endmodule

@@ rtl/battery_voltage_gauge.sv @@
// samples are taken one per cycle while a batch is collected
// after the last sample of a batch the result follows two serial divisions (no calibration or a
// negative calibrated value) or three (calibrated), a serial multiply and the state steps between
// them; input is stalled during that time and while the result waits on out_stall
// rst is synchronous: calibration clears, thresholds return to 3600/4200/120 mV,
// and the batch restarts empty
module battery_voltage_gauge
  import bvg_pkg::*;
#(
  parameter int SAMPLE_COUNT = BVG_SAMPLE_COUNT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   adc_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [MV_W-1:0]       voltage_mv,
  output logic                  battery_low,
  output logic [MV_W-1:0]       charge_level,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W   = $clog2(SAMPLE_COUNT);
  localparam int MCNT_W  = $clog2(SAMPLE_W + 1);

  localparam logic [3:0] S_ACC  = 4'd0;
  localparam logic [3:0] S_TRIM = 4'd1;
  localparam logic [3:0] S_MEAN = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_CONV = 4'd4;
  localparam logic [3:0] S_CDIV = 4'd5;
  localparam logic [3:0] S_LVL  = 4'd6;
  localparam logic [3:0] S_LDIV = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0] state;

  logic [SLOPE_W-1:0]  cal_slope;
  logic [OFFSET_W-1:0] cal_offset;
  logic [MV_W-1:0]     volt_min;
  logic [MV_W-1:0]     volt_max;
  logic [MV_W-1:0]     volt_step;

  logic [IDX_W-1:0]    sample_index;
  logic [SUM_W-1:0]    sample_sum;
  logic [SAMPLE_W-1:0] smallest_sample;
  logic [SAMPLE_W-1:0] largest_sample;

  logic [SAMPLE_W-1:0] mcand;
  logic [PROD_W-1:0]   prod;
  logic [MCNT_W-1:0]   mul_cnt;
  logic [MV_W-1:0]     mv;
  logic                below_min;

  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic [DIVR_W-1:0] div_divisor;
  logic              div_done;
  logic [DIV_W-1:0]  div_quo;

  logic                in_acc;
  logic                cal_default;
  logic [SUM_W-1:0]    trim_sub;
  logic [SUM_W-1:0]    trim;
  logic [SAMPLE_W:0]   mul_add;
  logic [CONV_W-1:0]   conv_sum;
  logic [MV_W-1:0]     step_eff;
  logic [MV_W-1:0]     lvl_dividend;
  logic [MV_W-1:0]     lvl_q;
  logic                out_free;

  assign in_acc      = in_valid && !in_stall;
  assign in_stall    = (state != S_ACC);
  assign cfg_ready   = 1'b1;
  assign out_free    = !out_valid || !out_stall;
  assign cal_default = (cal_slope == '0) && (cal_offset == '0);

  assign trim_sub = SUM_W'(smallest_sample) + SUM_W'(largest_sample);
  assign trim     = (sample_sum > trim_sub) ? (sample_sum - trim_sub) : '0;

  assign mul_add  = {1'b0, prod[PROD_W-1:SAMPLE_W]} + (prod[0] ? {1'b0, mcand} : '0);
  assign conv_sum = {2'b00, prod} + {{(CONV_W-OFFSET_W){cal_offset[OFFSET_W-1]}}, cal_offset};

  assign step_eff     = (volt_step == '0) ? MV_W'(1) : volt_step;
  assign lvl_dividend = (mv < volt_max) ? (mv - volt_min) :
                        ((volt_max > volt_min) ? (volt_max - volt_min) : '0);
  assign lvl_q        = div_quo[MV_W-1:0];

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (state)
      S_TRIM: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(trim);
        div_divisor  = DIVR_W'(SAMPLE_COUNT - 2);
      end
      S_CONV: begin
        div_start    = !cal_default && !conv_sum[CONV_W-1];
        div_dividend = conv_sum[DIV_W-1:0];
        div_divisor  = CAL_SCALE;
      end
      S_LVL: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(lvl_dividend);
        div_divisor  = DIVR_W'(step_eff);
      end
      default: begin
      end
    endcase
  end

  bvg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_slope  <= '0;
      cal_offset <= '0;
      volt_min   <= VOLT_MIN_RESET;
      volt_max   <= VOLT_MAX_RESET;
      volt_step  <= VOLT_STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CAL_SLOPE:  cal_slope  <= cfg_data[SLOPE_W-1:0];
        REG_CAL_OFFSET: cal_offset <= cfg_data[OFFSET_W-1:0];
        REG_VOLT_MIN:   volt_min   <= cfg_data[MV_W-1:0];
        REG_VOLT_MAX:   volt_max   <= cfg_data[MV_W-1:0];
        REG_VOLT_STEP:  volt_step  <= cfg_data[MV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_ACC;
      sample_index    <= '0;
      sample_sum      <= '0;
      smallest_sample <= SAMPLE_ALL_ONES;
      largest_sample  <= '0;
      out_valid       <= 1'b0;
      mul_cnt         <= '0;
    end else begin
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_ACC: begin
          if (in_acc) begin
            if (adc_sample < smallest_sample) begin
              smallest_sample <= adc_sample;
            end
            if (adc_sample > largest_sample) begin
              largest_sample <= adc_sample;
            end
            sample_sum <= sample_sum + SUM_W'(adc_sample);
            if (sample_index == IDX_W'(SAMPLE_COUNT - 1)) begin
              state <= S_TRIM;
            end else begin
              sample_index <= sample_index + 1'b1;
            end
          end
        end
        S_TRIM: begin
          sample_index    <= '0;
          sample_sum      <= '0;
          smallest_sample <= SAMPLE_ALL_ONES;
          largest_sample  <= '0;
          state           <= S_MEAN;
        end
        S_MEAN: begin
          if (div_done) begin
            mul_cnt <= MCNT_W'(SAMPLE_W);
            state   <= S_MUL;
          end
        end
        S_MUL: begin
          mul_cnt <= mul_cnt - 1'b1;
          if (mul_cnt == MCNT_W'(1)) begin
            state <= S_CONV;
          end
        end
        S_CONV: begin
          state <= (cal_default || conv_sum[CONV_W-1]) ? S_LVL : S_CDIV;
        end
        S_CDIV: begin
          if (div_done) begin
            state <= S_LVL;
          end
        end
        S_LVL: begin
          state <= S_LDIV;
        end
        S_LDIV: begin
          if (div_done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_ACC;
          end
        end
        default: begin
          state <= S_ACC;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_MEAN: begin
        if (div_done) begin
          mcand <= (|div_quo[DIV_W-1:SAMPLE_W]) ? SAMPLE_ALL_ONES : div_quo[SAMPLE_W-1:0];
          prod  <= {{SAMPLE_W{1'b0}}, (cal_default ? DEFAULT_GAIN : cal_slope)};
        end
      end
      S_MUL: begin
        prod <= {mul_add, prod[SAMPLE_W-1:1]};
      end
      S_CONV: begin
        if (cal_default) begin
          mv <= {prod[PROD_W-2:SAMPLE_W], 2'b00};
        end else if (conv_sum[CONV_W-1]) begin
          mv <= '0;
        end
      end
      S_CDIV: begin
        if (div_done) begin
          mv <= (|div_quo[DIV_W-1:MV_W-2]) ? MV_LIMIT : {div_quo[MV_W-3:0], 2'b00};
        end
      end
      S_LVL: begin
        below_min <= (mv < volt_min);
      end
      S_FIN: begin
        if (out_free) begin
          voltage_mv   <= mv;
          battery_low  <= (mv <= volt_min);
          charge_level <= (below_min || lvl_q == '0) ? '0 : (lvl_q - 1'b1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import bvg_pkg::*;

  localparam int BATCH      = BVG_SAMPLE_COUNT;
  localparam int PHASES     = 10;
  localparam int WAIT_MAX   = 15;
  localparam int SETTLE     = 100;
  localparam int LONG_HOLD  = 600;
  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    int unsigned         gap;
    bit                  drain;
  } sample_txn_t;

  typedef struct packed {
    logic [MV_W-1:0] mv;
    logic            low;
    logic [MV_W-1:0] level;
  } reading_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [SAMPLE_W-1:0]   adc_sample = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [MV_W-1:0]       voltage_mv;
  logic                  battery_low;
  logic [MV_W-1:0]       charge_level;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  battery_voltage_gauge u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .adc_sample   (adc_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .voltage_mv   (voltage_mv),
    .battery_low  (battery_low),
    .charge_level (charge_level),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // gauge settings as last written
  logic [SLOPE_W-1:0]         slope_q   = '0;
  logic signed [OFFSET_W-1:0] offset_q  = '0;
  logic [MV_W-1:0]            min_mv_q  = VOLT_MIN_RESET;
  logic [MV_W-1:0]            max_mv_q  = VOLT_MAX_RESET;
  logic [MV_W-1:0]            step_mv_q = VOLT_STEP_RESET;

  // running batch
  int unsigned         batch_fill = 0;
  logic [SUM_W-1:0]    batch_sum  = '0;
  logic [SAMPLE_W-1:0] batch_low  = SAMPLE_ALL_ONES;
  logic [SAMPLE_W-1:0] batch_high = '0;

  sample_txn_t pending_samples[$];
  reading_t    expected_readings[$];

  int unsigned mismatches = 0;
  int unsigned readings_checked = 0;
  int unsigned samples_taken = 0;
  int unsigned idle_cycles = 0;
  bit          in_took = 1'b0;
  bit          out_took = 1'b0;

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch: %s", msg);
  endfunction

  function automatic logic [MV_W-1:0] mv_from_mean(logic [SAMPLE_W-1:0] mean);
    longint acc;
    if (slope_q == '0 && offset_q == '0)
      return MV_W'(int'(mean) * int'(DEFAULT_GAIN) / (1 << SAMPLE_W) * 4);
    acc = longint'(mean) * longint'(slope_q) + longint'(offset_q);
    if (acc < 0)
      return '0;
    acc = (acc / longint'(CAL_SCALE)) * 4;
    if (acc > longint'(MV_LIMIT))
      return MV_LIMIT;
    return MV_W'(acc);
  endfunction

  function automatic logic [MV_W-1:0] level_from_mv(logic [MV_W-1:0] mv);
    int unsigned stride, levels, q;
    stride = (step_mv_q == '0) ? 1 : int'(step_mv_q);
    levels = (max_mv_q > min_mv_q) ? (int'(max_mv_q) - int'(min_mv_q)) / stride : 0;
    if (mv < min_mv_q)
      return '0;
    if (mv < max_mv_q) begin
      q = (int'(mv) - int'(min_mv_q)) / stride;
      return (q == 0) ? '0 : MV_W'(q - 1);
    end
    return (levels == 0) ? '0 : MV_W'(levels - 1);
  endfunction

  task automatic fold_sample(logic [SAMPLE_W-1:0] s);
    logic [SUM_W-1:0] trim;
    logic [SUM_W-1:0] mean;
    reading_t         r;
    if (s < batch_low)
      batch_low = s;
    if (s > batch_high)
      batch_high = s;
    batch_sum = batch_sum + s;
    if (batch_fill + 1 < BATCH) begin
      batch_fill++;
      return;
    end
    trim = batch_low + batch_high;
    trim = (batch_sum > trim) ? batch_sum - trim : '0;
    mean = trim / (BATCH - 2);
    if (mean > SAMPLE_ALL_ONES)
      mean = SUM_W'(SAMPLE_ALL_ONES);
    r.mv    = mv_from_mean(mean[SAMPLE_W-1:0]);
    r.low   = (r.mv <= min_mv_q);
    r.level = level_from_mv(r.mv);
    expected_readings.push_back(r);
    batch_fill = 0;
    batch_sum  = '0;
    batch_low  = SAMPLE_ALL_ONES;
    batch_high = '0;
  endtask

  // handshake sampling, prediction and checking
  always @(posedge clk) begin
    reading_t want;
    in_took  <= in_valid && !in_stall;
    out_took <= out_valid && !out_stall;
    if (!rst && in_valid && !in_stall) begin
      fold_sample(adc_sample);
      samples_taken++;
    end
    if (!rst && out_valid && !out_stall) begin
      readings_checked++;
      if (expected_readings.size() == 0) begin
        note_mismatch($sformatf("unexpected transaction mv=%0d low=%0d level=%0d",
                                voltage_mv, battery_low, charge_level));
      end else begin
        want = expected_readings.pop_front();
        if (voltage_mv !== want.mv || battery_low !== want.low ||
            charge_level !== want.level)
          note_mismatch($sformatf(
            "expected mv=%0d low=%0d level=%0d, got mv=%0d low=%0d level=%0d",
            want.mv, want.low, want.level, voltage_mv, battery_low, charge_level));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles == IDLE_LIMIT) begin
      $display("no transaction for %0d cycles", IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // sample driver
  sample_txn_t staged_txn;
  bit          staged = 1'b0;
  int unsigned gap_left = 0;

  always @(negedge clk) begin
    logic                next_valid;
    logic [SAMPLE_W-1:0] next_sample;
    next_valid  = in_valid && !in_took;
    next_sample = adc_sample;
    if (!rst && !next_valid) begin
      if (!staged && pending_samples.size() > 0) begin
        staged_txn = pending_samples.pop_front();
        gap_left   = staged_txn.gap;
        staged     = 1'b1;
      end
      if (staged) begin
        if (gap_left > 0)
          gap_left--;
        else if (!staged_txn.drain || expected_readings.size() == 0) begin
          next_valid  = 1'b1;
          next_sample = staged_txn.sample;
          staged      = 1'b0;
        end
      end
    end
    in_valid   <= next_valid;
    adc_sample <= next_sample;
  end

  // result receiver
  int unsigned stall_left = 0;
  bit          rx_eager = 1'b0;
  bit          long_hold_done = 1'b0;

  always @(negedge clk) begin
    if (out_took) begin
      if (!long_hold_done && readings_checked >= 4 && pending_samples.size() > 40) begin
        stall_left     = LONG_HOLD;
        long_hold_done = 1'b1;
      end else begin
        if (readings_checked % 16 == 0)
          rx_eager = ($urandom_range(0, 2) == 0);
        stall_left = rx_eager ? 0 : $urandom_range(0, WAIT_MAX);
      end
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else
      out_stall <= 1'b0;
  end

  task automatic queue_sample(logic [SAMPLE_W-1:0] s, int unsigned gap, bit drain);
    sample_txn_t t;
    t.sample = s;
    t.gap    = gap;
    t.drain  = drain;
    pending_samples.push_back(t);
  endtask

  task automatic queue_batch(bit drain_ok);
    int unsigned kind, centre, spread;
    int          v;
    bit          burst, drain;
    kind   = $urandom_range(0, 9);
    burst  = ($urandom_range(0, 3) == 0);
    drain  = drain_ok && ($urandom_range(0, 7) == 0);
    centre = (kind < 6) ? $urandom_range(2900, 3700) : $urandom_range(0, SAMPLE_ALL_ONES);
    spread = (kind == 9) ? 0 : $urandom_range(0, 60);
    for (int i = 0; i < BATCH; i++) begin
      if (kind == 8 || (kind < 6 && $urandom_range(0, 11) == 0)) begin
        v = $urandom_range(0, SAMPLE_ALL_ONES);
      end else begin
        v = int'(centre) + int'($urandom_range(0, 2 * spread)) - int'(spread);
        if (v < 0)
          v = 0;
        if (v > int'(SAMPLE_ALL_ONES))
          v = int'(SAMPLE_ALL_ONES);
      end
      queue_sample(SAMPLE_W'(v), burst ? 0 : $urandom_range(0, WAIT_MAX), drain && i == 0);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    case (idx)
      REG_CAL_SLOPE:  slope_q   = val[SLOPE_W-1:0];
      REG_CAL_OFFSET: offset_q  = val[OFFSET_W-1:0];
      REG_VOLT_MIN:   min_mv_q  = val[MV_W-1:0];
      REG_VOLT_MAX:   max_mv_q  = val[MV_W-1:0];
      REG_VOLT_STEP:  step_mv_q = val[MV_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(int unsigned phase);
    logic [SLOPE_W-1:0]         slope;
    logic signed [OFFSET_W-1:0] offset;
    logic [MV_W-1:0]            lo, hi, step;
    case (phase)
      1: begin
        slope = '0; offset = '0; lo = '0; hi = MV_LIMIT; step = 1;
      end
      2: begin
        slope = 3149; offset = -38000;
        lo = VOLT_MIN_RESET; hi = VOLT_MAX_RESET; step = VOLT_STEP_RESET;
      end
      // max not above min, largest slope and offset
      3: begin
        slope = '1; offset = {1'b0, {(OFFSET_W-1){1'b1}}}; lo = 2000; hi = 2000; step = MV_LIMIT;
      end
      // every calibrated value negative
      4: begin
        slope = 1; offset = {1'b1, {(OFFSET_W-1){1'b0}}}; lo = MV_LIMIT; hi = '0; step = 1;
      end
      5: begin
        slope = 2930; offset = 217000; lo = 3700; hi = 3900; step = 40;
      end
      // offset alone, voltage lands on the threshold
      6: begin
        slope = '0; offset = 217000; lo = 84; hi = 200; step = 1;
      end
      7: begin
        slope = '0; offset = '0; lo = VOLT_MIN_RESET; hi = VOLT_MAX_RESET; step = '0;
      end
      default: begin
        if ($urandom_range(0, 3) == 0) begin
          slope  = '0;
          offset = '0;
        end else begin
          slope  = SLOPE_W'($urandom_range(2700, 3149));
          offset = OFFSET_W'(int'($urandom_range(0, 255000)) - 38000);
        end
        lo   = MV_W'($urandom_range(750, 1050) * 4);
        hi   = lo + MV_W'($urandom_range(0, 1200));
        step = MV_W'($urandom_range(1, 300));
      end
    endcase
    write_reg(REG_CAL_SLOPE, CFG_DATA_W'(slope));
    write_reg(REG_CAL_OFFSET, CFG_DATA_W'(offset));
    write_reg(REG_VOLT_MIN, CFG_DATA_W'(lo));
    write_reg(REG_VOLT_MAX, CFG_DATA_W'(hi));
    write_reg(REG_VOLT_STEP, CFG_DATA_W'(step));
  endtask

  task automatic wait_quiet();
    while (pending_samples.size() != 0 || staged || in_valid || expected_readings.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int unsigned batches;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // full scale once followed by zeros, then full scale throughout
    queue_sample(SAMPLE_ALL_ONES, 0, 1'b0);
    repeat (BATCH - 1) queue_sample('0, 0, 1'b0);
    repeat (BATCH) queue_sample(SAMPLE_ALL_ONES, $urandom_range(0, WAIT_MAX), 1'b0);

    for (int phase = 1; phase <= PHASES; phase++) begin
      wait_quiet();
      apply_setting(phase);
      batches = $urandom_range(9, 10);
      for (int b = 0; b < batches; b++)
        queue_batch(phase >= 4);
      // partial batches carried across a settings change
      if (phase == 3)
        repeat (7) queue_sample(SAMPLE_W'($urandom_range(0, SAMPLE_ALL_ONES)),
                                $urandom_range(0, 3), 1'b0);
      if (phase == 5)
        repeat (5) queue_sample(SAMPLE_W'($urandom_range(0, SAMPLE_ALL_ONES)),
                                $urandom_range(0, 3), 1'b0);
    end
    wait_quiet();

    $display("covered %0d samples and %0d gauge readings over %0d register settings",
             samples_taken, readings_checked, PHASES + 1);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
